@@ sv/cfb_pkg.sv @@
// shared types, constants and the crc byte update for the frame builder
package cfb_pkg;

   localparam logic [7:0]  FRAME_HEAD = 8'hEA;
   localparam logic [7:0]  FRAME_TAIL = 8'hED;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETURN_CODE    = 2'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // byte positions inside a frame
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_HEAD    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ADDR    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SID_HI  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SID_LO  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RCODE   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CRC_HI  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CRC_LO  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_TAIL    = 4'd9;

   typedef enum logic {
      JOB_HEADER = 1'b0,
      JOB_DATA   = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         close;
      logic [15:0]  service_id;
      logic [15:0]  payload_length;
      logic [7:0]   payload_byte;
   } job_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ sv/crc16_frame_builder.sv @@
// top level of the crc16 frame builder: registers, front end, job queue, back end
//
//  channel  ports                                   direction  transfer when
//  req      req_valid/req_stall + 4 fields         in         valid & !stall
//  rsp      rsp_valid/rsp_stall + out_byte, end    out        valid & !stall
//  csr      csr_write_en, csr_index, csr_wdata     in         write_en
//
// a payload byte yields one output byte, or four when it closes the frame;
// a header yields seven output bytes, ten for an empty frame.
// the single output register gives one byte per cycle while rsp does not stall.
// reset is synchronous; it empties the job queue and closes any open frame.
// the four-entry job queue lets the front keep taking items while rsp stalls.
module crc16_frame_builder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [15:0]                     req_service_id,
   input  logic [15:0]                     req_payload_length,
   input  logic [7:0]                      req_payload_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_frame_end,
   input  logic                            csr_write_en,
   input  logic [cfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);
   import cfb_pkg::*;

   logic [7:0] device_address_ff;
   logic [7:0] return_code_ff;
   logic       push, pop, queue_full, head_valid;
   job_type    push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'd0;
         return_code_ff    <= 8'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata;
            CSR_RETURN_CODE:    return_code_ff    <= csr_wdata;
            default:            ;
         endcase
      end
   end

   cfb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_service_id     (req_service_id),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   cfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .device_address (device_address_ff),
      .return_code    (return_code_ff),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

@@ sv/cfb_front.sv @@
// front end: takes input items, tracks the open frame and queues jobs
module cfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_command,
   input  logic [15:0]      req_service_id,
   input  logic [15:0]      req_payload_length,
   input  logic [7:0]       req_payload_byte,
   input  logic             queue_full,
   output logic             push,
   output cfb_pkg::job_type push_job
);
   import cfb_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [15:0] remaining_ff, remaining_in;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      frame_open_in           = frame_open_ff;
      remaining_in            = remaining_ff;
      push                    = 1'b0;
      push_job.kind           = JOB_HEADER;
      push_job.close          = 1'b0;
      push_job.service_id     = req_service_id;
      push_job.payload_length = req_payload_length;
      push_job.payload_byte   = req_payload_byte;
      if (accept) begin
         if (req_command == 1'b0) begin
            // a header abandons any frame still open
            push           = 1'b1;
            push_job.kind  = JOB_HEADER;
            push_job.close = (req_payload_length == 16'd0);
            frame_open_in  = (req_payload_length != 16'd0);
            remaining_in   = req_payload_length;
         end else if (frame_open_ff) begin
            push           = 1'b1;
            push_job.kind  = JOB_DATA;
            push_job.close = (remaining_ff == 16'd1);
            remaining_in   = remaining_ff - 16'd1;
            frame_open_in  = (remaining_ff != 16'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
      end
   end

   a_open_matches_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (remaining_ff != 16'd0))
      else $error("frame open flag disagrees with byte count");

endmodule

@@ sv/cfb_queue.sv @@
// short job queue between front and back end
module cfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfb_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output cfb_pkg::job_type head_job
);
   import cfb_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

@@ sv/cfb_back.sv @@
// back end: serializes queued jobs into frame bytes and runs the crc
module cfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       device_address,
   input  logic [7:0]       return_code,
   input  logic             head_valid,
   input  cfb_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end
);
   import cfb_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [15:0]       crc_ff, crc_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              end_ff, end_in;
   logic              out_free, fire, last;
   logic [STEP_W-1:0] next_step;
   logic [7:0]        cur_byte;
   logic [15:0]       crc_base;

   assign out_free = !valid_ff || !rsp_stall;
   assign fire     = out_free && head_valid;

   always_comb begin
      case (step_ff)
         STEP_HEAD:   cur_byte = (head_job.kind == JOB_DATA) ? head_job.payload_byte
                                                              : FRAME_HEAD;
         STEP_ADDR:   cur_byte = device_address;
         STEP_SID_HI: cur_byte = head_job.service_id[15:8];
         STEP_SID_LO: cur_byte = head_job.service_id[7:0];
         STEP_RCODE:  cur_byte = return_code;
         STEP_LEN_HI: cur_byte = head_job.payload_length[15:8];
         STEP_LEN_LO: cur_byte = head_job.payload_length[7:0];
         STEP_CRC_HI: cur_byte = crc_ff[15:8];
         STEP_CRC_LO: cur_byte = crc_ff[7:0];
         STEP_TAIL:   cur_byte = FRAME_TAIL;
         default:     cur_byte = FRAME_TAIL;
      endcase
   end

   always_comb begin
      if (head_job.close) begin
         last = (step_ff == STEP_TAIL);
      end else if (head_job.kind == JOB_HEADER) begin
         last = (step_ff == STEP_LEN_LO);
      end else begin
         last = (step_ff == STEP_HEAD);
      end
      // a payload byte jumps straight to the closing bytes
      if (head_job.kind == JOB_DATA && step_ff == STEP_HEAD) begin
         next_step = STEP_CRC_HI;
      end else begin
         next_step = step_ff + STEP_W'(1);
      end
   end

   assign pop      = fire && last;
   assign crc_base = (head_job.kind == JOB_HEADER && step_ff == STEP_HEAD) ? CRC_INIT : crc_ff;

   always_comb begin
      step_in  = step_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (out_free) begin
         valid_in = fire;
      end
      if (fire) begin
         step_in = last ? STEP_HEAD : next_step;
         byte_in = cur_byte;
         end_in  = (step_ff == STEP_TAIL);
         if (step_ff <= STEP_LEN_LO) begin
            crc_in = crc_feed(crc_base, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_HEAD;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_TAIL)
      else $error("frame step out of range");

   a_end_is_tail: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> (byte_ff == FRAME_TAIL))
      else $error("frame end flag on a byte other than the tail");

endmodule
